@@ rtl/sgb_pkg.sv @@
`default_nettype none
package sgb_pkg;

    localparam int CFG_RADIUS   = 0;
    localparam int CFG_W_NEAR   = 1;
    localparam int CFG_W_FAR    = 2;
    localparam int CFG_WIDTH    = 3;
    localparam int CFG_HEIGHT   = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] IDX_RADIUS = CFG_IDX_W'(CFG_RADIUS);
    localparam logic [CFG_IDX_W-1:0] IDX_W_NEAR = CFG_IDX_W'(CFG_W_NEAR);
    localparam logic [CFG_IDX_W-1:0] IDX_W_FAR  = CFG_IDX_W'(CFG_W_FAR);
    localparam logic [CFG_IDX_W-1:0] IDX_WIDTH  = CFG_IDX_W'(CFG_WIDTH);
    localparam logic [CFG_IDX_W-1:0] IDX_HEIGHT = CFG_IDX_W'(CFG_HEIGHT);

    localparam logic [2:0]  RADIUS_RST  = 3'd1;
    localparam logic [63:0] W_NEAR_RST  = 64'd2605055999;
    localparam logic [63:0] W_FAR_RST   = 64'd0;
    localparam logic [10:0] WIDTH_RST   = 11'd640;
    localparam logic [15:0] HEIGHT_RST  = 16'd480;

    localparam int ACC_W  = 28;
    localparam int WSUM_W = 20;
    localparam int REM_W  = 29;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COL,
        ST_HTAP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_VRD,
        ST_VACC,
        ST_EMIT,
        ST_WRITE,
        ST_FINISH,
        ST_DNEXT
    } t_state;

    typedef struct packed {
        logic       shift_in;
        logic       acc_clr;
        logic       acc_en;
        logic       tap_cur;
        logic       tap_mem;
        logic       div_start;
        logic       hres_load;
        logic       out_load;
        logic       out_last;
        logic       mem_rd;
        logic       mem_wr;
        logic [2:0] wt_idx;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

@@ rtl/sgb_ctrl.sv @@
`default_nettype none
module sgb_ctrl
    import sgb_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic                              i_op,
    output logic                                   o_stall,
    input  wire logic                              i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]              i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]             i_cfg_data,
    output t_cmd                                   o_cmd,
    output logic [$clog2(2*MAX_RADIUS+1)-1:0]      o_win_idx,
    output logic [$clog2(2*MAX_RADIUS)-1:0]        o_slot,
    output logic [$clog2(MAX_WIDTH)-1:0]           o_col,
    input  t_stat                                  i_stat
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = CW + 2;
    localparam int SW = $clog2(2 * MAX_RADIUS);
    localparam int XW = $clog2(2 * MAX_RADIUS + 1);
    localparam int DW = $clog2(MAX_RADIUS * MAX_WIDTH + 1);

    t_state r_state, n_state;
    logic [2:0]  r_radius, n_radius;
    logic [10:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic [CW-1:0] r_col, n_col;
    logic [15:0] r_row, n_row;
    logic [SW-1:0] r_slot, n_slot;
    logic [DW-1:0] r_drain, n_drain;
    logic [15:0] r_dy, n_dy;
    logic [CW-1:0] r_dc, n_dc;
    logic [SW-1:0] r_last_slot, n_last_slot;
    logic [CW-1:0] r_x, n_x;
    logic [15:0] r_cur_row, n_cur_row;
    logic signed [PW-1:0] r_c, n_c;
    logic signed [PW-1:0] r_chi, n_chi;
    logic signed [4:0] r_i, n_i;
    logic signed [17:0] r_vy, n_vy;
    logic [15:0] r_ref_row, n_ref_row;
    logic [SW-1:0] r_ref_slot, n_ref_slot;
    logic r_has_cur, n_has_cur;
    logic r_vert, n_vert;
    logic r_drain_mode, n_drain_mode;
    logic r_flag_last, n_flag_last;

    logic [2:0]  eff_r;
    logic [WW-1:0] eff_w;
    logic [15:0] eff_h;
    logic [2:0]  rows_left;
    logic signed [4:0] r_s5;
    logic i_end;
    logic [CW-1:0] x_n;
    logic [15:0] row_n;
    logic signed [PW-1:0] x_s, p, c_lo, c_hi;
    logic h_valid;
    logic signed [17:0] yy, h_s, ref_s, d;
    logic v_valid, v_cur;
    logic [4:0] two_r, ref5, d5, slot5;
    logic [SW-1:0] v_slot;
    logic x_end, row_end;

    always_comb begin
        eff_r = (int'(r_radius) > MAX_RADIUS) ? 3'(MAX_RADIUS) : r_radius;
        if (r_width == 11'd0) begin
            eff_w = WW'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_width);
        end
        eff_h = (r_height == 16'd0) ? 16'd1 : r_height;
        rows_left = (16'(eff_r) < eff_h) ? eff_r : eff_h[2:0];
        r_s5 = $signed({2'b00, eff_r});
        i_end = (r_i == r_s5);
        two_r = {1'b0, eff_r, 1'b0};

        x_n = (WW'(r_col) >= eff_w) ? '0 : r_col;
        row_n = (r_row >= eff_h) ? 16'd0 : r_row;
        x_s = $signed({2'b00, x_n});
        c_lo = (x_n >= CW'(eff_r)) ? x_s - PW'(r_s5) : '0;
        c_hi = (WW'(x_n) == eff_w - WW'(1)) ? x_s : x_s - PW'(r_s5);

        // horizontal tap
        p = r_c + PW'(r_i);
        h_valid = (p >= 0) && (p <= $signed({2'b00, r_x}));
        o_win_idx = XW'($signed({2'b00, r_x}) - p);

        // vertical tap
        yy = r_vy + 18'(r_i);
        h_s = $signed({2'b00, eff_h});
        ref_s = $signed({2'b00, r_ref_row});
        v_valid = (yy >= 0) && (yy < h_s) && !(r_has_cur && (yy > ref_s));
        v_cur = r_has_cur && (yy == ref_s);
        d = ref_s - yy;
        d5 = d[4:0];
        ref5 = 5'(r_ref_slot);
        slot5 = (ref5 >= d5) ? ref5 - d5 : ref5 + two_r - d5;
        v_slot = SW'(slot5);

        x_end = (WW'(r_x) == eff_w - WW'(1));
        row_end = (r_cur_row == eff_h - 16'd1);
    end

    always_comb begin
        n_state = r_state;
        n_radius = r_radius;
        n_width = r_width;
        n_height = r_height;
        n_col = r_col;
        n_row = r_row;
        n_slot = r_slot;
        n_drain = r_drain;
        n_dy = r_dy;
        n_dc = r_dc;
        n_last_slot = r_last_slot;
        n_x = r_x;
        n_cur_row = r_cur_row;
        n_c = r_c;
        n_chi = r_chi;
        n_i = r_i;
        n_vy = r_vy;
        n_ref_row = r_ref_row;
        n_ref_slot = r_ref_slot;
        n_has_cur = r_has_cur;
        n_vert = r_vert;
        n_drain_mode = r_drain_mode;
        n_flag_last = r_flag_last;
        o_cmd = '0;
        o_cmd.wt_idx = r_i[4] ? 3'(-r_i) : 3'(r_i);
        o_slot = r_slot;
        o_col = r_c[CW-1:0];
        o_stall = (r_state != ST_IDLE);

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_op == OP_DRAIN) begin
                        if (r_drain != '0) begin
                            n_drain_mode = 1'b1;
                            n_has_cur = 1'b0;
                            n_vy = $signed({2'b00, r_dy});
                            n_ref_row = eff_h - 16'd1;
                            n_ref_slot = r_last_slot;
                            n_c = $signed({2'b00, r_dc});
                            n_i = -r_s5;
                            o_cmd.acc_clr = 1'b1;
                            n_state = ST_VRD;
                        end
                    end else begin
                        o_cmd.shift_in = 1'b1;
                        n_drain = '0;
                        n_drain_mode = 1'b0;
                        n_x = x_n;
                        n_cur_row = row_n;
                        if (r_row >= eff_h) begin
                            n_slot = '0;
                        end
                        n_c = c_lo;
                        n_chi = c_hi;
                        n_flag_last = (WW'(x_n) == eff_w - WW'(1))
                            && (row_n == eff_h - 16'd1) && (eff_r == 3'd0);
                        n_state = ST_COL;
                    end
                end
            end
            ST_COL: begin
                if (r_c > r_chi) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.acc_clr = 1'b1;
                    n_i = -r_s5;
                    n_state = ST_HTAP;
                end
            end
            ST_HTAP: begin
                o_cmd.acc_en = h_valid;
                if (i_end) begin
                    n_vert = 1'b0;
                    n_state = ST_DIV_GO;
                end else begin
                    n_i = r_i + 5'sd1;
                end
            end
            ST_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    if (r_vert) begin
                        n_state = ST_EMIT;
                    end else begin
                        o_cmd.hres_load = 1'b1;
                        if (r_cur_row >= 16'(eff_r)) begin
                            n_vy = $signed({2'b00, r_cur_row}) - 18'(r_s5);
                            n_has_cur = 1'b1;
                            n_ref_row = r_cur_row;
                            n_ref_slot = r_slot;
                            n_i = -r_s5;
                            o_cmd.acc_clr = 1'b1;
                            n_state = ST_VRD;
                        end else begin
                            n_state = ST_WRITE;
                        end
                    end
                end
            end
            ST_VRD: begin
                o_slot = v_slot;
                o_cmd.mem_rd = 1'b1;
                n_state = ST_VACC;
            end
            ST_VACC: begin
                o_cmd.acc_en = v_valid;
                o_cmd.tap_cur = v_cur;
                o_cmd.tap_mem = !v_cur;
                if (i_end) begin
                    n_vert = 1'b1;
                    n_state = ST_DIV_GO;
                end else begin
                    n_i = r_i + 5'sd1;
                    n_state = ST_VRD;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = r_drain_mode ? (r_drain == DW'(1)) : r_flag_last;
                    n_state = r_drain_mode ? ST_DNEXT : ST_WRITE;
                end
            end
            ST_WRITE: begin
                o_cmd.mem_wr = (eff_r != 3'd0);
                n_c = r_c + PW'(1);
                n_state = ST_COL;
            end
            ST_FINISH: begin
                if (x_end) begin
                    n_col = '0;
                    if (row_end) begin
                        n_row = 16'd0;
                        n_slot = '0;
                        n_last_slot = r_slot;
                        n_drain = DW'(DW'(rows_left) * DW'(eff_w));
                        n_dy = eff_h - 16'(rows_left);
                        n_dc = '0;
                    end else begin
                        n_row = r_cur_row + 16'd1;
                        if (eff_r != 3'd0) begin
                            n_slot = (5'(r_slot) + 5'd1 == two_r) ? '0 : r_slot + SW'(1);
                        end
                    end
                end else begin
                    n_col = r_x + CW'(1);
                    n_row = r_cur_row;
                end
                n_state = ST_IDLE;
            end
            ST_DNEXT: begin
                n_drain = r_drain - DW'(1);
                if (WW'(r_dc) == eff_w - WW'(1)) begin
                    n_dc = '0;
                    n_dy = r_dy + 16'd1;
                end else begin
                    n_dc = r_dc + CW'(1);
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // geometry writes restart the frame
        if (i_cfg_we) begin
            case (i_cfg_index)
                IDX_RADIUS, IDX_WIDTH, IDX_HEIGHT: begin
                    n_col = '0;
                    n_row = 16'd0;
                    n_slot = '0;
                    n_drain = '0;
                    if (i_cfg_index == IDX_RADIUS) begin
                        n_radius = i_cfg_data[2:0];
                    end
                    if (i_cfg_index == IDX_WIDTH) begin
                        n_width = i_cfg_data[10:0];
                    end
                    if (i_cfg_index == IDX_HEIGHT) begin
                        n_height = i_cfg_data[15:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_radius <= RADIUS_RST;
            r_width <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_col <= '0;
            r_row <= 16'd0;
            r_slot <= '0;
            r_drain <= '0;
            r_dy <= 16'd0;
            r_dc <= '0;
            r_last_slot <= '0;
            r_drain_mode <= 1'b0;
            r_vert <= 1'b0;
            r_has_cur <= 1'b0;
            r_flag_last <= 1'b0;
        end else begin
            r_state <= n_state;
            r_radius <= n_radius;
            r_width <= n_width;
            r_height <= n_height;
            r_col <= n_col;
            r_row <= n_row;
            r_slot <= n_slot;
            r_drain <= n_drain;
            r_dy <= n_dy;
            r_dc <= n_dc;
            r_last_slot <= n_last_slot;
            r_drain_mode <= n_drain_mode;
            r_vert <= n_vert;
            r_has_cur <= n_has_cur;
            r_flag_last <= n_flag_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_cur_row <= n_cur_row;
        r_c <= n_c;
        r_chi <= n_chi;
        r_i <= n_i;
        r_vy <= n_vy;
        r_ref_row <= n_ref_row;
        r_ref_slot <= n_ref_slot;
    end

endmodule
`default_nettype wire

@@ rtl/sgb_dp.sv @@
`default_nettype none
module sgb_dp
    import sgb_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [7:0]                        i_red_in,
    input  wire logic [7:0]                        i_green_in,
    input  wire logic [7:0]                        i_blue_in,
    input  wire logic                              i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]              i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]             i_cfg_data,
    input  t_cmd                                   i_cmd,
    input  wire logic [$clog2(2*MAX_RADIUS+1)-1:0] i_win_idx,
    input  wire logic [$clog2(2*MAX_RADIUS)-1:0]   i_slot,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]      i_col,
    output t_stat                                  o_stat,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [7:0]                             o_red_out,
    output logic [7:0]                             o_green_out,
    output logic [7:0]                             o_blue_out,
    output logic                                   o_frame_last
);

    localparam int WIN = 2 * MAX_RADIUS + 1;
    localparam int DEPTH = 2 * MAX_RADIUS * MAX_WIDTH;
    localparam int AW = $clog2(DEPTH);

    logic [23:0] r_win [WIN];
    logic [63:0] r_w_near, r_w_far;
    logic [ACC_W-1:0] r_acc [3];
    logic [WSUM_W-1:0] r_wsum;
    logic [REM_W-1:0] r_rem [3];
    logic [WSUM_W:0] r_den;
    logic [2:0] r_bit;
    logic r_dbusy;
    logic [7:0] r_q [3];
    logic [23:0] r_hres;
    logic [23:0] mem [DEPTH];
    logic [23:0] r_rdata;
    logic r_ovalid;
    logic [23:0] r_opix;
    logic r_olast;

    logic [127:0] w_all;
    logic [15:0] wt;
    logic [23:0] tap_pix;
    logic [AW-1:0] addr;
    logic [23:0] div_res;
    logic [REM_W-1:0] trial;

    always_comb begin
        w_all = {r_w_far, r_w_near};
        wt = w_all[{i_cmd.wt_idx, 4'b0000} +: 16];
        if (i_cmd.tap_cur) begin
            tap_pix = r_hres;
        end else if (i_cmd.tap_mem) begin
            tap_pix = r_rdata;
        end else begin
            tap_pix = r_win[i_win_idx];
        end
        addr = AW'(AW'(i_slot) * AW'(MAX_WIDTH)) + AW'(i_col);
        div_res = (r_den == '0) ? 24'd0 : {r_q[0], r_q[1], r_q[2]};
        trial = REM_W'(r_den) << r_bit;
        o_stat.div_done = !r_dbusy;
        o_stat.out_free = !r_ovalid || !i_stall;
        o_valid = r_ovalid;
        o_red_out = r_opix[23:16];
        o_green_out = r_opix[15:8];
        o_blue_out = r_opix[7:0];
        o_frame_last = r_olast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_near <= W_NEAR_RST;
            r_w_far <= W_FAR_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == IDX_W_NEAR) begin
                r_w_near <= i_cfg_data;
            end
            if (i_cfg_index == IDX_W_FAR) begin
                r_w_far <= i_cfg_data;
            end
        end
    end

    // row window of recent pixels, newest at the front
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN; k++) begin
                r_win[k] <= 24'd0;
            end
        end else if (i_cmd.shift_in) begin
            r_win[0] <= {i_red_in, i_green_in, i_blue_in};
            for (int k = 1; k < WIN; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    // weighted accumulate, one tap a cycle while acc_en is set
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            for (int k = 0; k < 3; k++) begin
                r_acc[k] <= '0;
            end
            r_wsum <= '0;
        end else if (i_cmd.acc_en) begin
            for (int k = 0; k < 3; k++) begin
                r_acc[k] <= r_acc[k] + ACC_W'(tap_pix[23-8*k -: 8]) * ACC_W'(wt);
            end
            r_wsum <= r_wsum + WSUM_W'(wt);
        end
    end

    // restoring divide, one quotient bit a cycle for all channels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_dbusy <= 1'b1;
        end else if (r_dbusy && r_bit == 3'd0) begin
            r_dbusy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[k] <= {r_acc[k], 1'b0} + REM_W'(r_wsum);
                r_q[k] <= 8'd0;
            end
            r_den <= {r_wsum, 1'b0};
            r_bit <= 3'd7;
        end else if (r_dbusy) begin
            for (int k = 0; k < 3; k++) begin
                if (r_rem[k] >= trial) begin
                    r_rem[k] <= r_rem[k] - trial;
                    r_q[k] <= {r_q[k][6:0], 1'b1};
                end else begin
                    r_q[k] <= {r_q[k][6:0], 1'b0};
                end
            end
            r_bit <= r_bit - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hres_load) begin
            r_hres <= div_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            mem[addr] <= r_hres;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_opix <= div_res;
            r_olast <= i_cmd.out_last;
        end
    end

endmodule
`default_nettype wire

@@ rtl/separable_gaussian_blur.sv @@
// Separable blur of a raster RGB888 stream: each pixel is filtered along its row with a
// symmetric 2R+1 tap kernel, the rounded row results are filtered down the column using
// line stores holding the previous 2R rows, and out-of-image taps are left out of both
// the sum and the divisor. The row pass takes one cycle a tap; the column pass reads
// tap from the line store, then accumulates it, and every division goes through a
// shared restoring divider. For every column that a pixel completes, the block runs the
// row pass and, once R rows are in, the column pass, whose result waits while
// the result register is stalled, and then writes the row result to the line store. A
// pixel before column R that does not end its row completes no column; the last pixel
// of a row completes R+1 columns at once, or the whole row if it is narrower. A drain
// tick after the frame flushes one pixel of the last R rows from the line store.
// Geometry writes restart the frame; weight writes act at once. Configure only while idle.
`default_nettype none
module separable_gaussian_blur
    import sgb_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_op,
    input  wire logic [7:0]            i_red_in,
    input  wire logic [7:0]            i_green_in,
    input  wire logic [7:0]            i_blue_in,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [7:0]                 o_red_out,
    output logic [7:0]                 o_green_out,
    output logic [7:0]                 o_blue_out,
    output logic                       o_frame_last,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;
    logic [$clog2(2*MAX_RADIUS+1)-1:0] win_idx;
    logic [$clog2(2*MAX_RADIUS)-1:0]   slot;
    logic [$clog2(MAX_WIDTH)-1:0]      col;

    sgb_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_op        (i_op),
        .o_stall     (o_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd),
        .o_win_idx   (win_idx),
        .o_slot      (slot),
        .o_col       (col),
        .i_stat      (stat)
    );

    sgb_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd),
        .i_win_idx    (win_idx),
        .i_slot       (slot),
        .i_col        (col),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_frame_last (o_frame_last)
    );

endmodule
`default_nettype wire

@@ rtl/sgb_checker.sv @@
`default_nettype none
module sgb_checker
    import sgb_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       i_op,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [7:0] o_red_out,
    input wire logic [7:0] o_green_out,
    input wire logic [7:0] o_blue_out,
    input wire logic       o_frame_last
);

    // a held result stays until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_red_out) && $stable(o_green_out)
            && $stable(o_blue_out) && $stable(o_frame_last))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("reset did not clear the channels");

    // a pixel always needs work, so input closes behind it
    a_pixel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_op == OP_PIXEL |=> o_stall)
        else $error("input open after pixel transfer");

endmodule

bind separable_gaussian_blur sgb_checker u_sgb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_op         (i_op),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_red_out    (o_red_out),
    .o_green_out  (o_green_out),
    .o_blue_out   (o_blue_out),
    .o_frame_last (o_frame_last)
);
`default_nettype wire
